/* sv/dflr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dflr_pkg
// Word types and codes shared by the fault log with rotating LED display.
// ----------------------------------------------------------------------------
package dflr_pkg;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_EVICTED   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;

    localparam logic [15:0] ROTATE_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  error_type;
        logic [7:0]  location;
        logic [31:0] description_id;
        logic [31:0] file_id;
        logic [15:0] line_number;
    } item_word_t;

    typedef struct packed {
        logic [7:0] led_pattern;
        logic [4:0] error_count;
        logic [2:0] status;
    } result_word_t;

endpackage

/* sv/dedup_fault_log_led_rotator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_fault_log_led_rotator_top
// Deduplicating fault log in a ring memory, with a rotating LED display.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall / item): one word per item, either
// an error report or a display tick. Every item gives exactly one result word
// on the output channel (result_valid / result_stall / result).
// Config channel (cfg_valid / cfg_ready / cfg_data) writes rotate_ticks; it is
// always ready and must only be written while the block is idle.
// One item at a time. A report walks the held entries through the entry
// RAM, one entry per cycle (registered read data, pipelined with the
// compare), then appends when no duplicate is found; a duplicate found
// early ends the walk sooner. Invalid reports go straight to completion,
// reports into an empty log go straight to the append step. A tick
// completes at once, or reads the shown entry back from the RAM when the
// display advances. The input stalls until the item completes and its
// result is taken into the output register.
// The result sits in an output register, so a new item is taken while an
// older result is still stalled; a finished item then waits until the
// output register frees up. Reset empties the log, clears the LEDs and the
// countdown and loads rotate_ticks with 1000; the RAM itself is not cleared,
// only held entries are ever read.
// ----------------------------------------------------------------------------
module dedup_fault_log_led_rotator_top #(
    parameter int DEPTH         = 16,
    parameter int LOCATION_BITS = 4,
    parameter int TYPE_BITS     = 4,
    parameter int LED_COUNT     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  dflr_pkg::item_word_t item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output dflr_pkg::result_word_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int TL_W = TYPE_BITS + LOCATION_BITS;
    localparam int KW   = TL_W + 80;
    localparam logic [7:0] LED_MASK = 8'((16'(1) << LED_COUNT) - 16'(1));

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_APPEND   = 3'd2;
    localparam logic [2:0] S_TICK_RD  = 3'd3;
    localparam logic [2:0] S_TICK_LED = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] display_reg, display_next;
    logic [15:0]   countdown_reg, countdown_next;
    logic [7:0]    led_reg, led_next;
    logic [2:0]    status_reg, status_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [KW-1:0] key_reg, key_next;
    logic [15:0]   rotate_ticks_reg;
    logic                   result_valid_reg;
    dflr_pkg::result_word_t result_reg;

    logic          item_take;
    logic          bad_fields;
    logic          full;
    logic [AW-1:0] logical;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot;
    logic [CW-1:0] display_inc;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          result_free;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_free  = !result_valid_reg || !result_stall;

    assign bad_fields = ((item.error_type >> TYPE_BITS) != 8'd0) ||
                        ((item.location >> LOCATION_BITS) != 8'd0);
    assign full = (count_reg == CW'(DEPTH));
    assign display_inc = CW'(display_reg) + CW'(1);

    // ring slot of a logical index, counted from the oldest entry
    always_comb
    begin
        case (state_reg)
            S_SCAN:    logical = scan_reg[AW-1:0];
            S_APPEND:  logical = count_reg[AW-1:0];
            S_TICK_RD: logical = display_reg;
            default:   logical = '0;
        endcase
        slot_sum = {1'b0, oldest_reg} + {1'b0, logical};
        if (slot_sum >= (AW + 1)'(DEPTH))
        begin
            slot = AW'(slot_sum - (AW + 1)'(DEPTH));
        end
        else
        begin
            slot = slot_sum[AW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        display_next   = display_reg;
        countdown_next = countdown_reg;
        led_next       = led_reg;
        status_next    = status_reg;
        scan_next      = scan_reg;
        key_next       = key_reg;
        rd_en          = 1'b0;
        rd_addr        = slot;
        wr_en          = 1'b0;
        wr_addr        = full ? oldest_reg : slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    key_next = {item.error_type[TYPE_BITS-1:0],
                                item.location[LOCATION_BITS-1:0],
                                item.description_id, item.file_id, item.line_number};
                    if (item.opcode == dflr_pkg::OP_TICK)
                    begin
                        status_next = dflr_pkg::ST_TICK;
                        state_next  = S_DONE;
                        if (count_reg == '0)
                        begin
                            led_next = '0;
                        end
                        else if (countdown_reg != '0)
                        begin
                            countdown_next = countdown_reg - 16'd1;
                        end
                        else
                        begin
                            // zero period behaves as one
                            countdown_next = (rotate_ticks_reg == '0) ? '0
                                                                      : rotate_ticks_reg - 16'd1;
                            display_next = (display_inc == count_reg) ? '0
                                                                      : display_inc[AW-1:0];
                            state_next = S_TICK_RD;
                        end
                    end
                    else if (bad_fields)
                    begin
                        status_next = dflr_pkg::ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        // first read goes to the oldest entry
                        rd_en      = 1'b1;
                        rd_addr    = oldest_reg;
                        scan_next  = CW'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data holds entry scan_reg - 1; next read is issued alongside
                if (rd_data == key_reg)
                begin
                    status_next = dflr_pkg::ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else if (scan_reg == count_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_APPEND:
            begin
                // when full the new entry replaces the oldest slot
                wr_en = 1'b1;
                if (full)
                begin
                    oldest_next = (oldest_reg == AW'(DEPTH - 1)) ? '0 : oldest_reg + AW'(1);
                    status_next = dflr_pkg::ST_EVICTED;
                end
                else
                begin
                    count_next  = count_reg + CW'(1);
                    status_next = dflr_pkg::ST_ADDED;
                end
                state_next = S_DONE;
            end
            S_TICK_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_TICK_LED;
            end
            S_TICK_LED:
            begin
                led_next   = 8'(rd_data[KW-TL_W +: LOCATION_BITS]) & LED_MASK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (result_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            oldest_reg       <= '0;
            count_reg        <= '0;
            display_reg      <= '0;
            countdown_reg    <= '0;
            led_reg          <= '0;
            rotate_ticks_reg <= dflr_pkg::ROTATE_TICKS_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            display_reg   <= display_next;
            countdown_reg <= countdown_next;
            led_reg       <= led_next;
            if (cfg_valid && cfg_ready)
            begin
                rotate_ticks_reg <= cfg_data;
            end
            if (state_reg == S_DONE && result_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        scan_reg   <= scan_next;
        key_reg    <= key_next;
        if (state_reg == S_DONE && result_free)
        begin
            result_reg.led_pattern <= led_reg;
            result_reg.error_count <= 5'(count_reg);
            result_reg.status      <= status_reg;
        end
    end

    // reads and writes never overlap: writes happen only in the append step
    dflr_entry_ram #(
        .DEPTH (DEPTH),
        .WIDTH (KW)
    ) u_entry_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("held count beyond ring depth");

    a_display_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> CW'(display_reg) < count_reg)
        else $error("display index outside held entries");

    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg != '0 && state_reg == S_DONE)
        else $error("append did not leave a held entry");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word raised outside completion");

endmodule

/* sv/dflr_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dflr_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dflr_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 88,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
